/* rtl/ufe_pkg.sv */
// Shared types and constants for the union-find engine.
// Used by the controller, the datapath, the top level and the checker.
`default_nettype none

package ufe_pkg;

    localparam int NODE_W         = 10;
    localparam int RANK_W         = 4;
    localparam int CNT_W          = 11;
    localparam int MAX_NODES_DEF  = 1024;
    localparam int NODE_COUNT_RST = 1024;
    localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

    // Read address sources for the table read port.
    localparam logic [1:0] RD_SEL_IN     = 2'd0;
    localparam logic [1:0] RD_SEL_Q      = 2'd1;
    localparam logic [1:0] RD_SEL_PARENT = 2'd2;

    typedef struct packed {
        logic              req_type;
        logic [NODE_W-1:0] node_p;
        logic [NODE_W-1:0] node_q;
    } ufe_req_t;

    typedef struct packed {
        logic              same_set;
        logic [NODE_W-1:0] root_p;
        logic [NODE_W-1:0] root_q;
        logic              range_error;
    } ufe_rsp_t;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic [NODE_W-1:0] parent;
    } ufe_entry_t;

    typedef struct packed {
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       req_load;
        logic       save_p;
        logic       save_q;
        logic       clr_reset;
        logic       clr_write;
        logic       link_a;
        logic       link_b;
        logic       out_load;
    } ufe_cmd_t;

    typedef struct packed {
        logic is_root;
        logic req_err;
        logic req_union;
        logic roots_differ;
        logic tie;
        logic clr_last;
        logic out_free;
    } ufe_sts_t;

endpackage

`default_nettype wire

/* rtl/union_find_engine_core.sv */
// Union-find engine with union by rank over a single-port-read node table.
// After reset, and after every node_count write, a clearing pass over min(MAX_NODES, 1024)
// entries rebuilds the table while req_ready stays low. A request walks from p to its root
// and then from q to its root, and a union that links two trees then writes the table once,
// or twice on a rank tie; each step of a walk is one read of the node table.
// A finished result sits in an output register, and the next request is accepted
// while it waits. Out-of-range requests return with range_error set, without a walk.
`default_nettype none

module union_find_engine_core
    import ufe_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_ready,
    input  wire ufe_req_t         req_data,
    output logic                  rsp_valid,
    input  wire logic             rsp_ready,
    output ufe_rsp_t              rsp_data,
    input  wire logic             cfg_wr_en,
    input  wire logic [CNT_W-1:0] cfg_wr_data
);

    ufe_cmd_t cmd;
    ufe_sts_t sts;

    ufe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .cfg_wr_en (cfg_wr_en),
        .sts       (sts),
        .cmd       (cmd)
    );

    ufe_dpath #(
        .MAX_NODES (MAX_NODES)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_data    (req_data),
        .rsp_ready   (rsp_ready),
        .rsp_valid   (rsp_valid),
        .rsp_data    (rsp_data),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

`default_nettype wire

/* rtl/ufe_ctrl.sv */
// Sequencer for the union-find engine: clearing pass, root walks, linking, result hand-off.
// Depends on ufe_pkg for the command and status structs.
`default_nettype none

module ufe_ctrl
    import ufe_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_ready,
    input  wire logic     cfg_wr_en,
    input  wire ufe_sts_t sts,
    output ufe_cmd_t      cmd
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_WALK_P = 3'd2;
    localparam logic [2:0] S_WALK_Q = 3'd3;
    localparam logic [2:0] S_LINK_A = 3'd4;
    localparam logic [2:0] S_LINK_B = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_write = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready = !cfg_wr_en;
                if (req_valid && !cfg_wr_en)
                begin
                    cmd.req_load = 1'b1;
                    cmd.rd_en    = 1'b1;
                    cmd.rd_sel   = RD_SEL_IN;
                    state_next   = S_WALK_P;
                end
            end
            S_WALK_P:
            begin
                if (sts.req_err)
                begin
                    state_next = S_DONE;
                end
                else if (sts.is_root)
                begin
                    cmd.save_p = 1'b1;
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_SEL_Q;
                    state_next = S_WALK_Q;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_SEL_PARENT;
                end
            end
            S_WALK_Q:
            begin
                if (sts.is_root)
                begin
                    cmd.save_q = 1'b1;
                    if (sts.req_union && sts.roots_differ)
                    begin
                        state_next = S_LINK_A;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_SEL_PARENT;
                end
            end
            S_LINK_A:
            begin
                cmd.link_a = 1'b1;
                state_next = sts.tie ? S_LINK_B : S_DONE;
            end
            S_LINK_B:
            begin
                cmd.link_b = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase

        // A node_count write re-initializes the forest from the first entry.
        if (cfg_wr_en)
        begin
            cmd.clr_reset = 1'b1;
            state_next    = S_CLEAR;
        end
    end

endmodule

`default_nettype wire

/* rtl/ufe_dpath.sv */
// Datapath of the union-find engine: node table memory, request and root registers,
// node_count register, clear counter and output register. Depends on ufe_pkg.
`default_nettype none

module ufe_dpath
    import ufe_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_wr_en,
    input  wire logic [CNT_W-1:0] cfg_wr_data,
    input  wire ufe_req_t         req_data,
    input  wire logic             rsp_ready,
    output logic                  rsp_valid,
    output ufe_rsp_t              rsp_data,
    input  wire ufe_cmd_t         cmd,
    output ufe_sts_t              sts
);

    // Only nodes below 2**NODE_W can ever be named, so deeper storage would go unused.
    localparam int DEPTH = (MAX_NODES < (1 << NODE_W)) ? MAX_NODES : (1 << NODE_W);
    localparam int AW    = $clog2(DEPTH);
    localparam int COUNT_RST = (NODE_COUNT_RST < MAX_NODES) ? NODE_COUNT_RST : MAX_NODES;

    ufe_entry_t mem [DEPTH];

    ufe_entry_t        rd_q_reg;
    logic [NODE_W-1:0] cur_reg;
    logic [NODE_W-1:0] rd_node;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    ufe_entry_t        wr_data;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [AW-1:0]     clr_reg;

    logic              union_reg;
    logic              err_reg;
    logic [NODE_W-1:0] q_reg;
    logic [NODE_W-1:0] root_p_reg;
    logic [NODE_W-1:0] root_q_reg;
    logic [RANK_W-1:0] rank_p_reg;
    logic [RANK_W-1:0] rank_q_reg;
    logic [RANK_W-1:0] rank_q_inc;

    logic              out_valid_reg;
    ufe_rsp_t          out_reg;

    always_comb
    begin
        case (cmd.rd_sel)
            RD_SEL_IN:     rd_node = req_data.node_p;
            RD_SEL_Q:      rd_node = q_reg;
            RD_SEL_PARENT: rd_node = rd_q_reg.parent;
            default:       rd_node = rd_q_reg.parent;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_q_reg <= mem[rd_node[AW-1:0]];
            cur_reg  <= rd_node;
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign rank_q_inc = (rank_q_reg == RANK_MAX) ? rank_q_reg : rank_q_reg + 1'b1;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = clr_reg;
        wr_data = '{rank: '0, parent: NODE_W'(clr_reg)};
        if (cmd.clr_write)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.link_a)
        begin
            wr_en = 1'b1;
            // The lower-ranked root goes under the other; on a tie the root of p goes under q.
            if (rank_p_reg <= rank_q_reg)
            begin
                wr_addr = root_p_reg[AW-1:0];
                wr_data = '{rank: rank_p_reg, parent: root_q_reg};
            end
            else
            begin
                wr_addr = root_q_reg[AW-1:0];
                wr_data = '{rank: rank_q_reg, parent: root_p_reg};
            end
        end
        else if (cmd.link_b)
        begin
            wr_en   = 1'b1;
            wr_addr = root_q_reg[AW-1:0];
            wr_data = '{rank: rank_q_inc, parent: root_q_reg};
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cfg_wr_en)
        begin
            if (32'(cfg_wr_data) > 32'(MAX_NODES))
            begin
                count_next = CNT_W'(MAX_NODES);
            end
            else
            begin
                count_next = cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= CNT_W'(COUNT_RST);
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.clr_reset)
            begin
                clr_reg <= '0;
            end
            else if (cmd.clr_write)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.req_load)
        begin
            union_reg <= req_data.req_type;
            q_reg     <= req_data.node_q;
            err_reg   <= ({1'b0, req_data.node_p} >= count_reg)
                      || ({1'b0, req_data.node_q} >= count_reg);
        end
        if (cmd.save_p)
        begin
            root_p_reg <= cur_reg;
            rank_p_reg <= rd_q_reg.rank;
        end
        if (cmd.save_q)
        begin
            root_q_reg <= cur_reg;
            rank_q_reg <= rd_q_reg.rank;
        end
        if (cmd.out_load)
        begin
            if (err_reg)
            begin
                out_reg <= '{same_set: 1'b0, root_p: '0, root_q: '0, range_error: 1'b1};
            end
            else
            begin
                out_reg <= '{same_set: (root_p_reg == root_q_reg), root_p: root_p_reg,
                             root_q: root_q_reg, range_error: 1'b0};
            end
        end
    end

    assign sts.is_root      = (rd_q_reg.parent == cur_reg);
    assign sts.req_err      = err_reg;
    assign sts.req_union    = union_reg;
    assign sts.roots_differ = (cur_reg != root_p_reg);
    assign sts.tie          = (rank_p_reg == rank_q_reg);
    assign sts.clr_last     = (clr_reg == AW'(DEPTH - 1));
    assign sts.out_free     = !out_valid_reg || rsp_ready;

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

endmodule

`default_nettype wire

/* rtl/ufe_checker.sv */
// Port-level checks for union_find_engine_core, attached by the bind at the end.
// Depends on ufe_pkg for the beat structs.
`default_nettype none

module ufe_checker
    import ufe_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             req_valid,
    input wire logic             req_ready,
    input wire ufe_req_t         req_data,
    input wire logic             rsp_valid,
    input wire logic             rsp_ready,
    input wire ufe_rsp_t         rsp_data,
    input wire logic             cfg_wr_en,
    input wire logic [CNT_W-1:0] cfg_wr_data
);

    // A result beat that is not taken holds.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("result beat changed while stalled");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.range_error |->
            !rsp_data.same_set && rsp_data.root_p == '0 && rsp_data.root_q == '0)
        else $error("range error beat carries nonzero fields");

    a_same_roots: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.range_error |->
            rsp_data.same_set == (rsp_data.root_p == rsp_data.root_q))
        else $error("same_set disagrees with the reported roots");

    // A node_count write starts a clearing pass, so no request can be taken right after it.
    a_cfg_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |=> !req_ready)
        else $error("request accepted during the clearing pass");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second request accepted while one is in flight");

endmodule

bind union_find_engine_core ufe_checker u_ufe_checker (.*);

`default_nettype wire

/* tb/sv/tb_union_find_engine_core.sv */
// Self-checking testbench for union_find_engine_core: a disjoint-set forest with union by rank.
// It depends on ufe_pkg for the request and response types, and keeps its own copy of the forest.
`timescale 1ns / 1ps

module tb_union_find_engine_core
    import ufe_pkg::*;
();

    localparam logic REQ_QUERY     = 1'b0;
    localparam logic REQ_UNION     = 1'b1;
    localparam int   CYCLE_LIMIT   = 500000;
    localparam int   SETTLE_CYCLES = 32;
    localparam int   DRAIN_CYCLES  = 64;
    localparam int   REPORT_MAX    = 10;

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t         kind;
        int                count;
        ufe_req_t          req;
        bit                typed;
        ufe_rsp_t          rsp;
    } plan_row_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             req_valid;
    logic             req_ready;
    ufe_req_t         req_data;
    logic             rsp_valid;
    logic             rsp_ready;
    ufe_rsp_t         rsp_data;
    logic             cfg_wr_en;
    logic [CNT_W-1:0] cfg_wr_data;

    // Typed expectation that travels with the request currently on the bus.
    bit               pend_typed;
    ufe_rsp_t         pend_exp;

    // Local copy of the forest.
    logic [NODE_W-1:0] forest_parent [MAX_NODES_DEF];
    logic [RANK_W-1:0] forest_rank   [MAX_NODES_DEF];
    int                forest_count;

    ufe_rsp_t  expect_q [$];
    plan_row_t plan [$];

    bit calm;
    int mismatches;
    int req_beats;
    int rsp_beats;
    int links_made;
    int range_hits;
    int deepest_walk;
    int cfg_writes;
    int cycles;

    union_find_engine_core #(
        .MAX_NODES (MAX_NODES_DEF)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req_data    (req_data),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp_data    (rsp_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #1 clk = ~clk;

    function automatic void forest_clear(int count_val);
        forest_count = (count_val > MAX_NODES_DEF) ? MAX_NODES_DEF : count_val;
        for (int k = 0; k < MAX_NODES_DEF; k++)
        begin
            forest_parent[k] = k[NODE_W-1:0];
            forest_rank[k]   = '0;
        end
    endfunction

    function automatic int root_of(int node);
        int cur;
        int steps;
        cur   = node;
        steps = 0;
        while (steps < MAX_NODES_DEF && forest_parent[cur] != cur)
        begin
            cur = forest_parent[cur];
            steps++;
        end
        if (steps > deepest_walk)
            deepest_walk = steps;
        return cur;
    endfunction

    // Applies one request to the local forest and returns the response it should produce.
    function automatic ufe_rsp_t forest_apply(ufe_req_t r);
        ufe_rsp_t o;
        int       rp;
        int       rq;
        o = '0;
        if (r.node_p >= forest_count || r.node_q >= forest_count)
        begin
            o.range_error = 1'b1;
            range_hits++;
            return o;
        end
        rp         = root_of(r.node_p);
        rq         = root_of(r.node_q);
        o.same_set = (rp == rq);
        o.root_p   = rp[NODE_W-1:0];
        o.root_q   = rq[NODE_W-1:0];
        if (r.req_type == REQ_UNION && rp != rq)
        begin
            if (forest_rank[rp] < forest_rank[rq])
                forest_parent[rp] = rq[NODE_W-1:0];
            else if (forest_rank[rp] > forest_rank[rq])
                forest_parent[rq] = rp[NODE_W-1:0];
            else
            begin
                // On a tie the root of p goes under the root of q, which gains a rank.
                forest_parent[rp] = rq[NODE_W-1:0];
                if (forest_rank[rq] != RANK_MAX)
                    forest_rank[rq] = forest_rank[rq] + 1'b1;
            end
            links_made++;
        end
        return o;
    endfunction

    function automatic ufe_rsp_t mk_rsp(int same, int rp, int rq, int err);
        ufe_rsp_t o;
        o.same_set    = same[0];
        o.root_p      = rp[NODE_W-1:0];
        o.root_q      = rq[NODE_W-1:0];
        o.range_error = err[0];
        return o;
    endfunction

    function automatic void plan_req(logic kind, int p, int q, bit typed, ufe_rsp_t exp);
        plan_row_t row;
        row.kind         = ROW_REQ;
        row.count        = 0;
        row.req.req_type = kind;
        row.req.node_p   = p[NODE_W-1:0];
        row.req.node_q   = q[NODE_W-1:0];
        row.typed        = typed;
        row.rsp          = exp;
        plan.push_back(row);
    endfunction

    function automatic void plan_cfg(int value);
        plan_row_t row;
        row.kind  = ROW_CFG;
        row.count = value;
        row.req   = '0;
        row.typed = 1'b0;
        row.rsp   = '0;
        plan.push_back(row);
    endfunction

    // Mostly short gaps, now and then a long one, and none at all in calm stretches.
    function automatic int pick_gap();
        int roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_req(ufe_req_t r, bit typed, ufe_rsp_t exp);
        req_valid  <= 1'b1;
        req_data   <= r;
        pend_typed <= typed;
        pend_exp   <= exp;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    task automatic idle_gap();
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // The count register is only written once every response is back and the core has settled.
    // The first edge lets the scoreboard book a request taken at the edge just passed.
    task automatic write_count(int value);
        req_valid <= 1'b0;
        @(posedge clk);
        while (expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value[CNT_W-1:0];
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        forest_clear(value);
        cfg_writes++;
    endtask

    task automatic run_phase(int cfg_val, int n_items, bit full_span);
        int       eff;
        int       span;
        ufe_req_t r;
        write_count(cfg_val);
        eff  = forest_count;
        span = full_span ? eff : $urandom_range((eff < 64) ? eff : 64, eff);
        for (int i = 0; i < n_items; i++)
        begin
            if (i % 50 == 0)
                calm = ($urandom_range(0, 3) == 0);
            r.req_type = ($urandom_range(0, 99) < 60) ? REQ_UNION : REQ_QUERY;
            r.node_p   = NODE_W'($urandom_range(0, span - 1));
            r.node_q   = NODE_W'($urandom_range(0, span - 1));
            if (eff < MAX_NODES_DEF && $urandom_range(0, 9) == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       r.node_p = NODE_W'($urandom_range(eff, MAX_NODES_DEF - 1));
                    1:       r.node_q = NODE_W'($urandom_range(eff, MAX_NODES_DEF - 1));
                    default:
                    begin
                        r.node_p = NODE_W'($urandom_range(eff, MAX_NODES_DEF - 1));
                        r.node_q = NODE_W'($urandom_range(eff, MAX_NODES_DEF - 1));
                    end
                endcase
            end
            send_req(r, 1'b0, '0);
            idle_gap();
        end
    endtask

    // Compares each response beat with the oldest expectation, then books the request taken.
    always @(posedge clk)
    begin : scoreboard
        ufe_rsp_t exp;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                rsp_beats++;
                if (expect_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("[%0t] response beat with nothing expected: %p", $realtime,
                                 rsp_data);
                end
                else
                begin
                    exp = expect_q.pop_front();
                    if (rsp_data.same_set !== exp.same_set || rsp_data.root_p !== exp.root_p
                        || rsp_data.root_q !== exp.root_q
                        || rsp_data.range_error !== exp.range_error)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("[%0t] beat %0d: expected same=%0d p=%0d q=%0d err=%0d,",
                                     $realtime, rsp_beats, exp.same_set, exp.root_p,
                                     exp.root_q, exp.range_error,
                                     " got same=%0d p=%0d q=%0d err=%0d",
                                     rsp_data.same_set, rsp_data.root_p,
                                     rsp_data.root_q, rsp_data.range_error);
                    end
                end
            end
            if (req_valid && req_ready)
            begin
                req_beats++;
                exp = forest_apply(req_data);
                expect_q.push_back(pend_typed ? pend_exp : exp);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d responses outstanding", cycles,
                     expect_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Response side: random stalls of mixed length between short bursts of ready.
    initial
    begin
        int stall;
        rsp_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = pick_gap();
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req_data    = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        pend_typed  = 1'b0;
        pend_exp    = '0;
        calm        = 1'b0;
        mismatches  = 0;
        req_beats   = 0;
        rsp_beats   = 0;
        links_made  = 0;
        range_hits  = 0;
        deepest_walk = 0;
        cfg_writes  = 0;
        cycles      = 0;
        forest_clear(NODE_COUNT_RST);

        // Directed part, starting from the reset forest of 1024 nodes.
        plan_req(REQ_QUERY, 0, 1023, 1'b1, mk_rsp(0, 0, 1023, 0));
        plan_req(REQ_QUERY, 1023, 1023, 1'b1, mk_rsp(1, 1023, 1023, 0));
        plan_req(REQ_UNION, 0, 1, 1'b1, mk_rsp(0, 0, 1, 0));
        plan_req(REQ_UNION, 0, 1, 1'b1, mk_rsp(1, 1, 1, 0));
        plan_req(REQ_UNION, 2, 3, 1'b1, mk_rsp(0, 2, 3, 0));
        plan_req(REQ_UNION, 0, 2, 1'b0, '0);
        plan_req(REQ_UNION, 4, 0, 1'b0, '0);
        plan_req(REQ_QUERY, 4, 1, 1'b0, '0);
        plan_req(REQ_UNION, 1023, 512, 1'b0, '0);
        plan_req(REQ_UNION, 682, 341, 1'b0, '0);
        plan_req(REQ_UNION, 1023, 682, 1'b0, '0);
        // A count of zero leaves no node in use.
        plan_cfg(0);
        plan_req(REQ_QUERY, 0, 0, 1'b1, mk_rsp(0, 0, 0, 1));
        plan_req(REQ_UNION, 1023, 1023, 1'b1, mk_rsp(0, 0, 0, 1));
        // An oversized count is held at the maximum, and the forest starts over.
        plan_cfg(2047);
        plan_req(REQ_QUERY, 1023, 0, 1'b1, mk_rsp(0, 1023, 0, 0));
        plan_cfg(1);
        plan_req(REQ_QUERY, 0, 0, 1'b1, mk_rsp(1, 0, 0, 0));
        plan_req(REQ_UNION, 0, 0, 1'b1, mk_rsp(1, 0, 0, 0));
        plan_req(REQ_QUERY, 0, 1, 1'b1, mk_rsp(0, 0, 0, 1));
        plan_req(REQ_UNION, 1, 0, 1'b1, mk_rsp(0, 0, 0, 1));
        plan_cfg(8);
        plan_req(REQ_UNION, 7, 6, 1'b1, mk_rsp(0, 7, 6, 0));
        plan_req(REQ_UNION, 8, 0, 1'b1, mk_rsp(0, 0, 0, 1));
        plan_req(REQ_QUERY, 7, 6, 1'b1, mk_rsp(1, 6, 6, 0));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
                write_count(plan[i].count);
            else
            begin
                send_req(plan[i].req, plan[i].typed, plan[i].rsp);
                idle_gap();
            end
        end

        // Random part; rewriting the same count must still clear the forest.
        run_phase(16, 90, 1'b1);
        run_phase(2, 40, 1'b1);
        run_phase(2047, 150, 1'b0);
        run_phase(1024, 150, 1'b1);
        run_phase(1024, 80, 1'b0);
        run_phase(300, 90, 1'b0);

        req_valid <= 1'b0;
        while (expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expect_q.size() != 0)
        begin
            mismatches++;
            $display("%0d expected responses never arrived", expect_q.size());
        end

        $display("Covered %0d request beats and %0d response beats over %0d count writes.",
                 req_beats, rsp_beats, cfg_writes);
        $display("Trees were linked %0d times, %0d requests fell out of range, longest walk %0d.",
                 links_made, range_hits, deepest_walk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
